// ===== rtl/ssc_pkg.sv =====
// Shared types, constants and a helper function for the segment-sphere contact block.
// Used by every module in rtl/ but ssc_delay; depends on nothing else.
package ssc_pkg;

  // Slice width of the partial-product multipliers.
  localparam int LIMB_W = 24;

  // Contact band register.
  localparam int            BAND_W     = 16;
  localparam logic [15:0]   BAND_RESET = 16'd164;

  // Result beat width: the two-bit contact code padded to a byte.
  localparam int OUT_W = 8;

  // Where the closest point of the segment lies.
  typedef enum logic [1:0] {
    CASE_START,
    CASE_END,
    CASE_INSIDE
  } seg_case_t;

  // Contact classification.
  typedef enum logic [1:0] {
    CONTACT_NONE  = 2'd0,
    CONTACT_TOUCH = 2'd1,
    CONTACT_SINK  = 2'd2
  } contact_t;

  // Control bits that follow an item down the pipeline.
  typedef struct packed {
    seg_case_t seg;
    logic      band_covers;
  } ctl_t;

  // Register stages of ssc_mul for the given operand widths: one product stage
  // plus one adder-tree level per halving of the partial-product count.
  function automatic int mul_latency(input int a_w, input int b_w);
    int n;
    n = ((a_w + LIMB_W - 1) / LIMB_W) * ((b_w + LIMB_W - 1) / LIMB_W);
    return 1 + $clog2(n);
  endfunction

endpackage

// ===== rtl/segment_sphere_contact.sv =====
// Top level of the segment-sphere contact classifier.
// Instantiates ssc_front, ssc_mul and ssc_delay; depends on ssc_pkg.

// Each input beat carries a segment and a sphere; one result beat comes back per
// input beat, in order, with contact code 0 (no contact), 1 (touching within the
// band) or 2 (sinking in). The block takes a new beat in every cycle unless the
// result side stalls it. Each beat passes through ssc_front, the two chained
// limb multiplier ranks that form the exact squared products and the output
// register. A stall on the result side holds the whole pipeline only once its
// last stage is occupied, so bubbles are squeezed out while a finished result
// waits. contact_band may be written only while no beat is in flight.
module segment_sphere_contact #(
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 12
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z, center_x, center_y, center_z,
  // sphere_size, sphere_scale, then zero padding
  input  logic [((11*COORD_BITS + 5) / 8) * 8 - 1:0] s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // contact_class, then zero padding
  output logic [ssc_pkg::OUT_W-1:0]              m_axis_tdata,
  input  logic                                   cfg_we,
  input  logic [ssc_pkg::BAND_W-1:0]             cfg_wdata
);
  import ssc_pkg::*;

  localparam int SQ_W  = 2 * COORD_BITS + 2;
  localparam int R_W   = 2 * COORD_BITS - 2;
  localparam int M1_W  = 2 * SQ_W;
  localparam int M2_W  = M1_W + SQ_W;
  localparam int LAT1  = mul_latency(SQ_W, SQ_W);
  localparam int LAT2  = mul_latency(M1_W, SQ_W);
  localparam int CTL_W = $bits(ctl_t);
  localparam int SH    = 2 * FRAC_BITS + 2;
  localparam int D1_W  = 1 + CTL_W + 2 * SQ_W;
  localparam int D2_W  = 2 + M1_W;

  // Contact band register.
  logic [BAND_W-1:0] contact_band;

  always_ff @(posedge clk) begin
    if (rst) begin
      contact_band <= BAND_RESET;
    end else if (cfg_we) begin
      contact_band <= cfg_wdata;
    end
  end

  // Pipeline advance: the output register can load, or the last stage is empty.
  logic out_load;
  logic pipe_en;
  logic d2_valid;

  assign out_load      = !m_axis_tvalid || m_axis_tready;
  assign pipe_en       = out_load || !d2_valid;
  assign s_axis_tready = pipe_en;

  // Unpack the input beat.
  logic [COORD_BITS-1:0] seg_start [3];
  logic [COORD_BITS-1:0] seg_end [3];
  logic [COORD_BITS-1:0] center [3];
  logic [COORD_BITS-2:0] sphere_size;
  logic [COORD_BITS-2:0] sphere_scale;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      seg_start[i] = s_axis_tdata[i*COORD_BITS +: COORD_BITS];
      seg_end[i]   = s_axis_tdata[(3 + i)*COORD_BITS +: COORD_BITS];
      center[i]    = s_axis_tdata[(6 + i)*COORD_BITS +: COORD_BITS];
    end
    sphere_size  = s_axis_tdata[9*COORD_BITS +: COORD_BITS - 1];
    sphere_scale = s_axis_tdata[10*COORD_BITS - 1 +: COORD_BITS - 1];
  end

  // Front end: differences, products, sums, case selection.
  logic            f_valid;
  ctl_t            f_ctl;
  logic [SQ_W-1:0] f_ndir;
  logic [SQ_W-1:0] f_q;
  logic [SQ_W-1:0] f_wsq;
  logic [SQ_W-1:0] f_lsq;
  logic [SQ_W-1:0] f_dmag;
  logic [R_W-1:0]  f_radius;
  logic [R_W-1:0]  f_trim;

  ssc_front #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .en           (pipe_en),
    .in_valid     (s_axis_tvalid),
    .seg_start    (seg_start),
    .seg_end      (seg_end),
    .center       (center),
    .sphere_size  (sphere_size),
    .sphere_scale (sphere_scale),
    .band         (contact_band),
    .out_valid    (f_valid),
    .ctl          (f_ctl),
    .n_direct     (f_ndir),
    .q            (f_q),
    .w_sq         (f_wsq),
    .l_sq         (f_lsq),
    .dot_mag      (f_dmag),
    .radius       (f_radius),
    .trim         (f_trim)
  );

  // First multiplier rank: |w|^2 * |v|^2, dot^2, radius^2 and trimmed radius^2.
  logic [M1_W-1:0] wl;
  logic [M1_W-1:0] dd;
  logic [M1_W-1:0] rr;
  logic [M1_W-1:0] tt;

  ssc_mul #(.A_W(SQ_W), .B_W(SQ_W)) u_mul_wl (
    .clk (clk), .en (pipe_en), .a (f_wsq), .b (f_lsq), .p (wl)
  );

  ssc_mul #(.A_W(SQ_W), .B_W(SQ_W)) u_mul_dd (
    .clk (clk), .en (pipe_en), .a (f_dmag), .b (f_dmag), .p (dd)
  );

  ssc_mul #(.A_W(SQ_W), .B_W(SQ_W)) u_mul_rr (
    .clk (clk), .en (pipe_en), .a (SQ_W'(f_radius)), .b (SQ_W'(f_radius)), .p (rr)
  );

  ssc_mul #(.A_W(SQ_W), .B_W(SQ_W)) u_mul_tt (
    .clk (clk), .en (pipe_en), .a (SQ_W'(f_trim)), .b (SQ_W'(f_trim)), .p (tt)
  );

  logic            d1_valid;
  ctl_t            d1_ctl;
  logic [SQ_W-1:0] d1_ndir;
  logic [SQ_W-1:0] d1_q;
  logic [D1_W-1:0] d1_out;

  ssc_delay #(.W(D1_W), .DEPTH(LAT1)) u_delay1 (
    .clk (clk),
    .rst (rst),
    .en  (pipe_en),
    .d   ({f_valid, f_ctl, f_ndir, f_q}),
    .q   (d1_out)
  );

  assign {d1_valid, d1_ctl, d1_ndir, d1_q} = d1_out;

  // Scaled squared distance numerator for the chosen case.
  logic [M1_W-1:0] n_comb;

  always_comb begin
    if (d1_ctl.seg == CASE_INSIDE) begin
      n_comb = wl - dd;
    end else begin
      n_comb = M1_W'(d1_ndir);
    end
  end

  // Second multiplier rank: thresholds times the common denominator.
  logic [M2_W-1:0] rq;
  logic [M2_W-1:0] tq;

  ssc_mul #(.A_W(M1_W), .B_W(SQ_W)) u_mul_rq (
    .clk (clk), .en (pipe_en), .a (rr), .b (d1_q), .p (rq)
  );

  ssc_mul #(.A_W(M1_W), .B_W(SQ_W)) u_mul_tq (
    .clk (clk), .en (pipe_en), .a (tt), .b (d1_q), .p (tq)
  );

  logic            d2_covers;
  logic [M1_W-1:0] d2_n;
  logic [D2_W-1:0] d2_out;

  ssc_delay #(.W(D2_W), .DEPTH(LAT2)) u_delay2 (
    .clk (clk),
    .rst (rst),
    .en  (pipe_en),
    .d   ({d1_valid, d1_ctl.band_covers, n_comb}),
    .q   (d2_out)
  );

  assign {d2_valid, d2_covers, d2_n} = d2_out;

  // Final classification against the exact squared thresholds.
  logic [M2_W-1:0] nk;
  contact_t        cls_c;
  contact_t        out_cls;

  always_comb begin
    nk = M2_W'(d2_n) << SH;
    if (nk > rq) begin
      cls_c = CONTACT_NONE;
    end else if (d2_covers || (nk >= tq)) begin
      cls_c = CONTACT_TOUCH;
    end else begin
      cls_c = CONTACT_SINK;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cls <= cls_c;
    end
  end

  assign m_axis_tdata = OUT_W'(out_cls);

endmodule

// ===== rtl/ssc_front.sv =====
// Front end of the contact pipeline: differences, small products, sums and case selection.
// Four register stages; depends on ssc_pkg.
module ssc_front #(
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [COORD_BITS-1:0]       seg_start [3],
  input  logic [COORD_BITS-1:0]       seg_end [3],
  input  logic [COORD_BITS-1:0]       center [3],
  input  logic [COORD_BITS-2:0]       sphere_size,
  input  logic [COORD_BITS-2:0]       sphere_scale,
  input  logic [ssc_pkg::BAND_W-1:0]  band,
  output logic                        out_valid,
  output ssc_pkg::ctl_t               ctl,
  output logic [2*COORD_BITS+1:0]     n_direct,
  output logic [2*COORD_BITS+1:0]     q,
  output logic [2*COORD_BITS+1:0]     w_sq,
  output logic [2*COORD_BITS+1:0]     l_sq,
  output logic [2*COORD_BITS+1:0]     dot_mag,
  output logic [2*COORD_BITS-3:0]     radius,
  output logic [2*COORD_BITS-3:0]     trim
);
  import ssc_pkg::*;

  localparam int D_W   = COORD_BITS + 1;
  localparam int P_W   = 2 * D_W;
  localparam int SQ_W  = 2 * COORD_BITS + 2;
  localparam int DOT_W = SQ_W + 1;
  localparam int R_W   = 2 * COORD_BITS - 2;
  localparam int BS_W  = BAND_W + FRAC_BITS + 1;
  localparam int CMP_W = (R_W > BS_W) ? R_W : BS_W;

  // Stage 1: coordinate differences.
  logic                 s1_valid;
  logic signed [D_W-1:0] s1_w [3];
  logic signed [D_W-1:0] s1_v [3];
  logic signed [D_W-1:0] s1_f [3];
  logic [COORD_BITS-2:0] s1_size;
  logic [COORD_BITS-2:0] s1_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_w[i] <= $signed({center[i][COORD_BITS-1], center[i]})
                 - $signed({seg_start[i][COORD_BITS-1], seg_start[i]});
        s1_v[i] <= $signed({seg_end[i][COORD_BITS-1], seg_end[i]})
                 - $signed({seg_start[i][COORD_BITS-1], seg_start[i]});
        s1_f[i] <= $signed({center[i][COORD_BITS-1], center[i]})
                 - $signed({seg_end[i][COORD_BITS-1], seg_end[i]});
      end
      s1_size  <= sphere_size;
      s1_scale <= sphere_scale;
    end
  end

  // Stage 2: per-axis products and the scaled radius.
  logic signed [P_W-1:0] wv_c [3];
  logic signed [P_W-1:0] ww_c [3];
  logic signed [P_W-1:0] vv_c [3];
  logic signed [P_W-1:0] ff_c [3];
  logic [R_W-1:0]        r_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wv_c[i] = P_W'(s1_w[i]) * P_W'(s1_v[i]);
      ww_c[i] = P_W'(s1_w[i]) * P_W'(s1_w[i]);
      vv_c[i] = P_W'(s1_v[i]) * P_W'(s1_v[i]);
      ff_c[i] = P_W'(s1_f[i]) * P_W'(s1_f[i]);
    end
    r_c = R_W'(s1_size) * R_W'(s1_scale);
  end

  logic                  s2_valid;
  logic signed [P_W-1:0] s2_wv [3];
  logic [SQ_W-1:0]       s2_ww [3];
  logic [SQ_W-1:0]       s2_vv [3];
  logic [SQ_W-1:0]       s2_ff [3];
  logic [R_W-1:0]        s2_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_wv[i] <= wv_c[i];
        s2_ww[i] <= SQ_W'(unsigned'(ww_c[i]));
        s2_vv[i] <= SQ_W'(unsigned'(vv_c[i]));
        s2_ff[i] <= SQ_W'(unsigned'(ff_c[i]));
      end
      s2_r <= r_c;
    end
  end

  // Stage 3: dot product and squared lengths.
  logic                    s3_valid;
  logic signed [DOT_W-1:0] s3_dot;
  logic [SQ_W-1:0]         s3_wsq;
  logic [SQ_W-1:0]         s3_lsq;
  logic [SQ_W-1:0]         s3_fsq;
  logic [R_W-1:0]          s3_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_dot <= DOT_W'(s2_wv[0]) + DOT_W'(s2_wv[1]) + DOT_W'(s2_wv[2]);
      s3_wsq <= s2_ww[0] + s2_ww[1] + s2_ww[2];
      s3_lsq <= s2_vv[0] + s2_vv[1] + s2_vv[2];
      s3_fsq <= s2_ff[0] + s2_ff[1] + s2_ff[2];
      s3_r   <= s2_r;
    end
  end

  // Stage 4: pick the closest-point case and compare the band against the radius.
  logic              is_start;
  logic              is_end;
  logic [SQ_W-1:0]   dpos;
  logic [CMP_W-1:0]  band_ext;
  logic [CMP_W-1:0]  r_ext;
  logic [CMP_W-1:0]  diff;
  logic              covers;

  always_comb begin
    dpos     = s3_dot[SQ_W-1:0];
    is_start = s3_dot[DOT_W-1] || (s3_dot == '0);
    is_end   = !is_start && (dpos >= s3_lsq);
    band_ext = CMP_W'({band, {(FRAC_BITS + 1){1'b0}}});
    r_ext    = CMP_W'(s3_r);
    covers   = band_ext >= r_ext;
    diff     = r_ext - band_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (is_start) begin
        ctl.seg  <= CASE_START;
        n_direct <= s3_wsq;
        q        <= SQ_W'(1);
      end else if (is_end) begin
        ctl.seg  <= CASE_END;
        n_direct <= s3_fsq;
        q        <= SQ_W'(1);
      end else begin
        ctl.seg  <= CASE_INSIDE;
        n_direct <= s3_wsq;
        q        <= s3_lsq;
      end
      ctl.band_covers <= covers;
      w_sq    <= s3_wsq;
      l_sq    <= s3_lsq;
      dot_mag <= dpos;
      radius  <= s3_r;
      trim    <= covers ? '0 : R_W'(diff);
    end
  end

endmodule

// ===== rtl/ssc_mul.sv =====
// Pipelined wide unsigned multiplier built from limb partial products and an adder tree.
// Register stages: the partial products, then the adder-tree levels; depends on ssc_pkg.
module ssc_mul #(
  parameter int A_W = 50,
  parameter int B_W = 50
) (
  input  logic             clk,
  input  logic             en,
  input  logic [A_W-1:0]   a,
  input  logic [B_W-1:0]   b,
  output logic [A_W+B_W-1:0] p
);
  import ssc_pkg::*;

  localparam int P_W  = A_W + B_W;
  localparam int NA   = (A_W + LIMB_W - 1) / LIMB_W;
  localparam int NB   = (B_W + LIMB_W - 1) / LIMB_W;
  localparam int N    = NA * NB;
  localparam int LVL  = $clog2(N);
  localparam int AX_W = NA * LIMB_W;
  localparam int BX_W = NB * LIMB_W;
  localparam int PP_W = 2 * LIMB_W;

  logic [AX_W-1:0] a_ext;
  logic [BX_W-1:0] b_ext;
  logic [PP_W-1:0] prod [0:N-1];
  logic [P_W-1:0]  tree [0:LVL][0:N-1];

  // Limb-by-limb products, each no wider than one limb by one limb.
  always_comb begin
    a_ext = AX_W'(a);
    b_ext = BX_W'(b);
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        prod[i*NB + j] = PP_W'(a_ext[i*LIMB_W +: LIMB_W]) * PP_W'(b_ext[j*LIMB_W +: LIMB_W]);
      end
    end
  end

  // Register the aligned partial products, then add pairs level by level.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          tree[0][i*NB + j] <= P_W'(prod[i*NB + j]) << ((i + j) * LIMB_W);
        end
      end
      for (int l = 1; l <= LVL; l++) begin
        for (int k = 0; k < N; k++) begin
          if (2*k + 1 < N) begin
            tree[l][k] <= tree[l-1][2*k] + tree[l-1][2*k + 1];
          end else if (2*k < N) begin
            tree[l][k] <= tree[l-1][2*k];
          end else begin
            tree[l][k] <= '0;
          end
        end
      end
    end
  end

  assign p = tree[LVL][0];

endmodule

// ===== rtl/ssc_delay.sv =====
// Enable-gated delay line that carries an item's side data alongside a multiplier.
// Self-contained; depends on nothing else.
module ssc_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] line [0:DEPTH-1];

  // Shift one place each time the pipeline advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      line <= '{default: '0};
    end else if (en) begin
      line[0] <= d;
      for (int k = 1; k < DEPTH; k++) begin
        line[k] <= line[k-1];
      end
    end
  end

  assign q = line[DEPTH-1];

endmodule

// ===== rtl/ssc_check.sv =====
// Port-level checks for segment_sphere_contact and the bind that attaches them.
// Depends on ssc_pkg and the top-level port list.
module ssc_check (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [ssc_pkg::OUT_W-1:0] m_axis_tdata
);
  import ssc_pkg::*;

  // A result beat held back by the sink stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // With the output register empty, the input side is never stalled.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output register");

  // A sink that takes every beat never throttles the source.
  a_ready_follows_sink: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while the sink is ready");

  // Reset leaves no result beat behind.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result beat present right after reset");

endmodule

bind segment_sphere_contact ssc_check u_ssc_check (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== verif/segment_sphere_contact_tb.sv =====
// Self-checking testbench for segment_sphere_contact: directed and random
// segment/sphere beats, with an exact wide-integer contact classifier in the bench.
// Depends on rtl/ssc_pkg.sv and rtl/segment_sphere_contact.sv.
module segment_sphere_contact_tb;
  import ssc_pkg::*;

  localparam int COORD_W     = 24;
  localparam int FRAC        = 12;
  localparam int TDATA_W     = ((11 * COORD_W + 5) / 8) * 8;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_ITEMS = 650;

  // One input beat; the packed order puts start_x in the lowest bits.
  typedef struct packed {
    logic [COORD_W-2:0]          scale;
    logic [COORD_W-2:0]          size;
    logic [2:0][COORD_W-1:0]     center;
    logic [2:0][COORD_W-1:0]     seg_end;
    logic [2:0][COORD_W-1:0]     seg_start;
  } segment_beat_t;

  // Wide enough for (dist^2 << 26) and radius^2 * |v|^2.
  typedef logic [255:0] wide_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [OUT_W-1:0]   m_axis_tdata;
  logic               cfg_we = 1'b0;
  logic [BAND_W-1:0]  cfg_wdata = '0;

  logic [BAND_W-1:0]  band_shadow = BAND_RESET;
  contact_t           pending_class[$];
  contact_t           want_class;
  int                 error_count = 0;
  int                 cycle_count = 0;
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;
  int                 stall_cycles_left = 0;

  segment_sphere_contact uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Exact classification: squared distance n/q against the radius, which is
  // size*scale in units of 2^-13 of a coordinate LSB.
  function automatic contact_t classify_contact(input segment_beat_t b,
                                                input logic [BAND_W-1:0] band);
    longint s, e, c, w, v, f;
    longint dot, len2, wsq, fsq;
    wide_t  n, q, r, band_w, t, lhs;
    dot = 0; len2 = 0; wsq = 0; fsq = 0;
    for (int i = 0; i < 3; i++) begin
      s = longint'($signed(b.seg_start[i]));
      e = longint'($signed(b.seg_end[i]));
      c = longint'($signed(b.center[i]));
      w = c - s;
      v = e - s;
      f = c - e;
      dot  += w * v;
      len2 += v * v;
      wsq  += w * w;
      fsq  += f * f;
    end
    // Closest point: start, end, or foot of the perpendicular.
    if (dot <= 0) begin
      n = wide_t'(wsq);
      q = wide_t'(1);
    end else if (dot >= len2) begin
      n = wide_t'(fsq);
      q = wide_t'(1);
    end else begin
      n = wide_t'(wsq) * wide_t'(len2) - wide_t'(dot) * wide_t'(dot);
      q = wide_t'(len2);
    end
    r      = wide_t'(b.size) * wide_t'(b.scale);
    band_w = wide_t'(band) << (FRAC + 1);
    lhs    = n << (2 * FRAC + 2);
    if (lhs > r * r * q) return CONTACT_NONE;
    if (band_w >= r) return CONTACT_TOUCH;
    t = r - band_w;
    if (lhs >= t * t * q) return CONTACT_TOUCH;
    return CONTACT_SINK;
  endfunction

  function automatic segment_beat_t make_beat(input int sx, sy, sz, ex, ey, ez,
                                              input int cx, cy, cz, size, scale);
    segment_beat_t b;
    b.seg_start[0] = COORD_W'(sx); b.seg_start[1] = COORD_W'(sy);
    b.seg_start[2] = COORD_W'(sz);
    b.seg_end[0]   = COORD_W'(ex); b.seg_end[1]   = COORD_W'(ey);
    b.seg_end[2]   = COORD_W'(ez);
    b.center[0]    = COORD_W'(cx); b.center[1]    = COORD_W'(cy);
    b.center[2]    = COORD_W'(cz);
    b.size  = (COORD_W-1)'(size);
    b.scale = (COORD_W-1)'(scale);
    return b;
  endfunction

  function automatic real rand_unit();
    return real'($urandom_range(2000000)) / 1000000.0 - 1.0;
  endfunction

  function automatic logic [COORD_W-1:0] clip_coord(input real x);
    if (x > 8388607.0) return 24'h7FFFFF;
    if (x < -8388608.0) return 24'h800000;
    return COORD_W'($rtoi(x));
  endfunction

  // Sphere placed so its surface falls near the segment, either at the contact
  // edge or at the edge of the touching band, with a mix of degenerate cases.
  function automatic segment_beat_t make_near_contact(input logic [BAND_W-1:0] band);
    segment_beat_t b;
    real span, t, dot, len2, frac, d2, radius, scl, sz, dd;
    real s[3], e[3], c[3], v[3];
    int  pick, bw;
    logic zero_len;
    bw = int'(band);
    span = real'(1 << $urandom_range(22, 3));
    zero_len = ($urandom_range(9) == 0);
    t = rand_unit() * 0.8 + 0.5;
    for (int i = 0; i < 3; i++) begin
      s[i] = span * rand_unit();
      e[i] = zero_len ? s[i] : span * rand_unit();
      c[i] = s[i] + t * (e[i] - s[i]) + 0.5 * span * rand_unit() * rand_unit();
      b.seg_start[i] = clip_coord(s[i]);
      b.seg_end[i]   = clip_coord(e[i]);
      b.center[i]    = clip_coord(c[i]);
    end
    pick = $urandom_range(19);
    if (pick == 0) b.center = b.seg_start;
    if (pick == 1) b.center = b.seg_end;

    // Distance from the clipped integer values.
    dot = 0.0; len2 = 0.0; d2 = 0.0;
    for (int i = 0; i < 3; i++) begin
      s[i] = real'($signed(b.seg_start[i]));
      c[i] = real'($signed(b.center[i]));
      v[i] = real'($signed(b.seg_end[i])) - s[i];
      dot  += (c[i] - s[i]) * v[i];
      len2 += v[i] * v[i];
    end
    frac = (len2 > 0.0) ? dot / len2 : 0.0;
    if (frac < 0.0) frac = 0.0;
    if (frac > 1.0) frac = 1.0;
    for (int i = 0; i < 3; i++) begin
      dd = c[i] - s[i] - frac * v[i];
      d2 += dd * dd;
    end

    case ($urandom_range(2))
      0:       radius = $sqrt(d2) + real'($urandom_range(40)) - 20.0;
      1:       radius = $sqrt(d2) + real'(bw) + real'($urandom_range(40)) - 20.0;
      default: radius = $sqrt(d2) + real'($urandom_range(3 * bw + 2000)) - real'(bw + 1000);
    endcase
    if (radius < 0.0) radius = 0.0;
    scl = real'($urandom_range(1 << 17, 256));
    sz  = radius * 8192.0 / scl + 0.5;
    if (sz > 8388607.0) sz = 8388607.0;
    b.scale = (COORD_W-1)'($rtoi(scl));
    b.size  = (COORD_W-1)'($rtoi(sz));
    pick = $urandom_range(19);
    if (pick == 0) b.size = '0;
    if (pick == 1) b.scale = '0;
    return b;
  endfunction

  // Every field random over its full width; size and scale over varied magnitudes.
  function automatic segment_beat_t make_noise();
    segment_beat_t b;
    for (int i = 0; i < 3; i++) begin
      b.seg_start[i] = COORD_W'($urandom);
      b.seg_end[i]   = COORD_W'($urandom);
      b.center[i]    = COORD_W'($urandom);
    end
    b.size  = (COORD_W-1)'($urandom) >> $urandom_range(22, 0);
    b.scale = (COORD_W-1)'($urandom) >> $urandom_range(22, 0);
    return b;
  endfunction

  // Offer one beat, with a random gap first, and record its expected class
  // at the edge where it is taken.
  task automatic send_segment(input segment_beat_t b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= TDATA_W'(b);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_class.push_back(classify_contact(b, band_shadow));
  endtask

  task automatic wait_drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_class.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_band(input logic [BAND_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    band_shadow = value;
  endtask

  // Edges of each class, the three closest-point cases, zero-length segments,
  // degenerate spheres and the coordinate extremes, all at the reset band.
  task automatic test_directed();
    send_segment(make_beat(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Perpendicular foot at distance 200: radius 200, 199.5, 364, 365.
    send_segment(make_beat(-400, 0, 0, 400, 0, 0, 0, 200, 0, 400, 4096));
    send_segment(make_beat(-400, 0, 0, 400, 0, 0, 0, 200, 0, 399, 4096));
    send_segment(make_beat(-400, 0, 0, 400, 0, 0, 0, 200, 0, 728, 4096));
    send_segment(make_beat(-400, 0, 0, 400, 0, 0, 0, 200, 0, 730, 4096));
    // Center behind the start and beyond the end.
    send_segment(make_beat(-400, 0, 0, 400, 0, 0, -600, 100, 0, 800, 4096));
    send_segment(make_beat(-400, 0, 0, 400, 0, 0, 700, 0, 0, 600, 4096));
    // Projection exactly at the start and exactly at the end.
    send_segment(make_beat(0, 0, 0, 1000, 0, 0, 0, 300, 0, 600, 4096));
    send_segment(make_beat(0, 0, 0, 1000, 0, 0, 1000, 300, 0, 600, 4096));
    // Zero-length segment acts as a point.
    send_segment(make_beat(50, 50, 50, 50, 50, 50, 53, 50, 50, 6, 4096));
    send_segment(make_beat(50, 50, 50, 50, 50, 50, 53, 50, 50, 4, 4096));
    // Degenerate spheres: off the segment, on its interior, on its start.
    send_segment(make_beat(0, 0, 0, 1000, 0, 0, 100, 1, 0, 0, 4096));
    send_segment(make_beat(0, 0, 0, 1000, 0, 0, 100, 0, 0, 0, 4096));
    send_segment(make_beat(7, -3, 9, 1000, 0, 0, 7, -3, 9, 4096, 0));
    // Band wider than the radius: any contact touches.
    send_segment(make_beat(0, 0, 0, 1000, 0, 0, 500, 0, 0, 200, 4096));
    // Coordinate and size extremes.
    send_segment(make_beat(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
                           8388607, -8388608, 0, 8388607, 8388607));
    send_segment(make_beat(8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
                           -8388608, -8388608, -8388608, 0, 8388607));
    send_segment(make_beat(-8388608, 8388607, -8388608, 8388607, -8388608, 8388607,
                           -8388608, -8388608, 8388607, 8388607, 1));
    send_segment(make_beat(8388607, -8388608, 0, -8388608, 8388607, 0,
                           0, 0, 8388607, 1, 8388607));
    send_segment(make_beat(-8388608, 0, 0, 8388607, 0, 0, 0, 8388607, -8388608,
                           8388607, 8388607));
    wait_drain();
  endtask

  // Band at zero and at its maximum, with penetration just at and past it.
  task automatic test_band_extremes();
    write_band(16'd0);
    send_segment(make_beat(-400, 0, 0, 400, 0, 0, 0, 200, 0, 400, 4096));
    send_segment(make_beat(-400, 0, 0, 400, 0, 0, 0, 200, 0, 401, 4096));
    send_segment(make_beat(-400, 0, 0, 400, 0, 0, 0, 200, 0, 399, 4096));
    wait_drain();
    write_band(16'hFFFF);
    send_segment(make_beat(0, 0, 0, 1000, 0, 0, 500, 0, 0, 131070, 4096));
    send_segment(make_beat(0, 0, 0, 1000, 0, 0, 500, 0, 0, 131072, 4096));
    send_segment(make_beat(0, 0, 0, 1000, 0, 0, 500, 70000, 0, 131072, 4096));
    wait_drain();
    write_band(BAND_RESET);
  endtask

  task automatic run_random_items(input int count);
    segment_beat_t b;
    repeat (count) begin
      if ($urandom_range(3) == 0) b = make_noise();
      else b = make_near_contact(band_shadow);
      send_segment(b);
    end
    wait_drain();
  endtask

  // Three random phases, each with its own band and idle pattern.
  task automatic test_random_stream();
    write_band(BAND_W'($urandom_range(4095)));
    send_idle_pct = 25;
    recv_idle_pct = 47;
    run_random_items(PHASE_ITEMS);
    write_band(BAND_W'($urandom_range(1023)));
    send_idle_pct = 47;
    recv_idle_pct = 25;
    run_random_items(PHASE_ITEMS);
    write_band(BAND_W'($urandom));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_items(PHASE_ITEMS);
  endtask

  // Result side held off long enough for the pipeline to fill and stall input.
  task automatic test_output_stall();
    write_band(BAND_RESET);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk);
    stall_cycles_left = 400;
    run_random_items(80);
  endtask

  // Result-side ready, with a long hold-off when one is requested.
  always @(negedge clk) begin
    if (stall_cycles_left > 0) begin
      stall_cycles_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare every result beat with the oldest expected class.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_class.size() == 0) begin
        $error("unexpected result beat: contact_class actual %0d", m_axis_tdata[1:0]);
        error_count++;
      end else begin
        want_class = pending_class.pop_front();
        if (m_axis_tdata[1:0] !== want_class) begin
          $error("contact_class: expected %0d, actual %0d", want_class,
                 m_axis_tdata[1:0]);
          error_count++;
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[segment_sphere_contact] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_band_extremes();
    test_random_stream();
    test_output_stall();
    wait_drain();
    if (error_count == 0) begin
      $display("[segment_sphere_contact] OK");
    end else begin
      $display("[segment_sphere_contact] ERROR");
    end
    $finish;
  end

endmodule
